// ----- hdl/tmi_pkg.sv -----
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared types, constants and saturating helpers for the triangular inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package tmi_pkg;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam logic [1:0] REG_UPPER_MODE   = 2'd0;
  localparam logic [1:0] REG_UNIT_DIAG    = 2'd1;
  localparam logic [1:0] REG_SIZE_IN_USE  = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic zero_div;
  } alu_rsp_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

  // Signed result from a magnitude and a sign, saturated to 32 bits.
  function automatic logic signed [31:0] from_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      if (m >= 64'h8000_0000) from_mag = Q_MIN;
      else from_mag = -$signed(m[31:0]);
    end else begin
      if (m > 64'h7FFF_FFFF) from_mag = Q_MAX;
      else from_mag = $signed(m[31:0]);
    end
  endfunction

  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] x);
    sat_neg = (x == Q_MIN) ? Q_MAX : -x;
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) sat_sub = d[32] ? Q_MIN : Q_MAX;
    else sat_sub = d[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tmi_ram.sv -----
// ----------------------------------------------------------------------------
// tmi_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/tmi_alu.sv -----
// ----------------------------------------------------------------------------
// tmi_alu
// Shared fixed-point unit: rounded multiply and bit-serial rounded divide
// (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module tmi_alu #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tmi_pkg::alu_req_t   req,
  input  wire logic signed [31:0]  a,
  input  wire logic signed [31:0]  b,
  output tmi_pkg::alu_rsp_t        rsp,
  output logic signed [31:0]       result
);

  localparam int NW   = 32 + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_RND  = 4'b1000
  } alu_state_t;

  alu_state_t         state;
  logic signed [63:0] prod;
  logic [NW-1:0]      quo;
  logic [31:0]        rem;
  logic [31:0]        den;
  logic               neg;
  logic [CNTW-1:0]    cnt;
  logic               done;
  logic               zdiv;

  logic [32:0]   rem2;
  logic          ge;
  logic [63:0]   pmag;
  logic [63:0]   prnd;
  logic [NW:0]   qrnd;

  always_comb begin
    rem2 = {rem, quo[NW-1]};
    ge   = rem2 >= {1'b0, den};
    pmag = prod[63] ? 64'(-prod) : 64'(prod);
    prnd = (pmag + HALF) >> FRAC_BITS;
    qrnd = {1'b0, quo} + (NW+1)'({rem, 1'b0} >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      zdiv  <= 1'b0;
    end else begin
      done <= 1'b0;
      zdiv <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            if (req.op == tmi_pkg::OP_MUL) begin
              prod  <= a * b;
              state <= A_MUL;
            end else if (b == 32'sd0) begin
              result <= a[31] ? tmi_pkg::Q_MIN : tmi_pkg::Q_MAX;
              zdiv   <= 1'b1;
              done   <= 1'b1;
            end else begin
              quo   <= NW'(tmi_pkg::mag32(a)) << FRAC_BITS;
              den   <= tmi_pkg::mag32(b);
              rem   <= 32'd0;
              neg   <= a[31] ^ b[31];
              cnt   <= CNTW'(NW);
              state <= A_DIV;
            end
          end
        end
        A_MUL: begin
          result <= tmi_pkg::from_mag(prnd, prod[63]);
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        A_DIV: begin
          rem <= ge ? 32'(rem2 - {1'b0, den}) : rem2[31:0];
          quo <= {quo[NW-2:0], ge};
          cnt <= cnt - CNTW'(1);
          if (cnt == CNTW'(1)) begin
            state <= A_RND;
          end
        end
        A_RND: begin
          result <= tmi_pkg::from_mag(64'(qrnd), neg);
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp.done     = done;
  assign rsp.zero_div = zdiv;

endmodule

`default_nettype wire

// ----- hdl/triangular_matrix_inverse.sv -----
// ----------------------------------------------------------------------------
// triangular_matrix_inverse
// Inverts a lower or upper triangular Q16.16 matrix by column substitution.
// ----------------------------------------------------------------------------
// Usage: the source matrix arrives on the input channel (in_valid/in_ready,
// field element), one word per entry, column-major, n*n words where n comes
// from size_in_use. Input words are taken only while the block is loading.
// The word that completes the matrix starts the inversion and in_ready stays
// low until the whole inverse has been delivered. The inversion runs on one
// shared multiply/divide unit; the divider dominates at small n.
// The inverse then leaves on the output channel (out_valid/out_ready) in
// column-major order, out_valid low after each accepted word, last_element
// on the final word, and singular on every word if a used diagonal was zero.
// A stalled receiver simply holds the block in its emit state with the word
// unchanged. Synchronous reset returns to loading with an empty count and the
// configuration at lower, non-unit, n = 8. Configuration writes are taken at
// any time but are meant only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module triangular_matrix_inverse #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [3:0]         wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] element,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      inverse_element,
  output logic                    last_element,
  output logic                    singular
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int TW    = $clog2(CELLS + 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // Sequencer states. Each read state issues a memory read whose data is
  // used in the following state.
  typedef enum logic [14:0] {
    ST_LOAD = 15'b000000000000001,
    ST_DIAG = 15'b000000000000010,
    ST_DGO  = 15'b000000000000100,
    ST_DGW  = 15'b000000000001000,
    ST_OFF  = 15'b000000000010000,
    ST_OGO  = 15'b000000000100000,
    ST_OMW  = 15'b000000001000000,
    ST_KRD  = 15'b000000010000000,
    ST_KGO  = 15'b000000100000000,
    ST_KMW  = 15'b000001000000000,
    ST_PRD  = 15'b000010000000000,
    ST_PGO  = 15'b000100000000000,
    ST_PDW  = 15'b001000000000000,
    ST_WR   = 15'b010000000000000,
    ST_EMIT = 15'b100000000000000
  } seq_state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] rr,
                                              input logic [IW-1:0] cc,
                                              input logic [DW-1:0] nn);
    cell_addr = AW'(TW'(rr) + TW'(cc) * TW'(nn));
  endfunction

  // Configuration registers.
  logic       upper_mode;
  logic       unit_diagonal;
  logic [3:0] size_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_mode    <= 1'b0;
      unit_diagonal <= 1'b0;
      size_in_use   <= 4'd8;
    end else if (wr_en) begin
      priority case (wr_index)
        tmi_pkg::REG_UPPER_MODE:  upper_mode    <= wr_data[0];
        tmi_pkg::REG_UNIT_DIAG:   unit_diagonal <= wr_data[0];
        tmi_pkg::REG_SIZE_IN_USE: size_in_use   <= wr_data;
        default: ;
      endcase
    end
  end

  // Dimension in use: zero acts as one, anything past MAX_DIM is clamped.
  logic [DW-1:0] dim;
  logic [TW-1:0] total;

  always_comb begin
    if (size_in_use == 4'd0) dim = DW'(1);
    else if (int'(size_in_use) > MAX_DIM) dim = DW'(MAX_DIM);
    else dim = DW'(size_in_use);
    total = TW'(dim) * TW'(dim);
  end

  seq_state_t         state;
  logic [AW-1:0]      cnt;
  logic [IW-1:0]      r;
  logic [IW-1:0]      c;
  logic [IW-1:0]      k;
  logic signed [31:0] acc;
  logic signed [31:0] diag;
  logic               sing;

  logic signed [31:0] src_q;
  logic signed [31:0] inv_q;
  logic [AW-1:0]      src_raddr;
  logic [AW-1:0]      inv_raddr;
  logic               in_acc;
  logic               out_acc;

  tmi_pkg::alu_req_t  alu_req;
  tmi_pkg::alu_rsp_t  alu_rsp;
  logic signed [31:0] alu_a;
  logic signed [31:0] alu_b;
  logic signed [31:0] alu_res;

  assign in_ready = (state == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_comb begin
    unique case (state)
      ST_DIAG: src_raddr = cell_addr(c, c, dim);
      ST_KRD:  src_raddr = cell_addr(r, k, dim);
      ST_PRD:  src_raddr = cell_addr(r, r, dim);
      default: src_raddr = cell_addr(r, c, dim);
    endcase
    inv_raddr = (state == ST_KRD) ? cell_addr(k, c, dim) : cell_addr(r, c, dim);
  end

  tmi_ram #(.WIDTH(32), .DEPTH(CELLS)) u_src (
    .clk   (clk),
    .we    (in_acc),
    .waddr (cnt),
    .wdata (element),
    .raddr (src_raddr),
    .rdata (src_q)
  );

  tmi_ram #(.WIDTH(32), .DEPTH(CELLS)) u_inv (
    .clk   (clk),
    .we    (state == ST_WR),
    .waddr (cell_addr(r, c, dim)),
    .wdata (acc),
    .raddr (inv_raddr),
    .rdata (inv_q)
  );

  // Requests to the shared unit.
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = tmi_pkg::OP_MUL;
    alu_a         = src_q;
    alu_b         = diag;
    unique case (state)
      ST_DGO: begin
        alu_req.start = !unit_diagonal;
        alu_req.op    = tmi_pkg::OP_DIV;
        alu_a         = ONE;
        alu_b         = src_q;
      end
      ST_OGO: begin
        alu_req.start = !unit_diagonal;
      end
      ST_KGO: begin
        alu_req.start = 1'b1;
        alu_a         = inv_q;
        alu_b         = src_q;
      end
      ST_PGO: begin
        alu_req.start = 1'b1;
        alu_req.op    = tmi_pkg::OP_DIV;
        alu_a         = acc;
        alu_b         = src_q;
      end
      default: ;
    endcase
  end

  tmi_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .rsp    (alu_rsp),
    .result (alu_res)
  );

  // Loop bookkeeping. Lower walks rows and k upward from the diagonal, upper
  // walks them downward.
  logic [DW:0]   r_ext;
  logic [DW:0]   c_ext;
  logic [IW-1:0] k_first;
  logic          k_first_ok;
  logic [IW-1:0] k_nx;
  logic          k_nx_ok;
  logic          row_more;
  logic [IW-1:0] row_nx;
  logic          col_more;
  seq_state_t    pivot_state;
  logic          out_zero;
  logic          out_last;
  logic          out_col_end;

  always_comb begin
    r_ext       = (DW+1)'(r);
    c_ext       = (DW+1)'(c);
    k_first     = upper_mode ? c - IW'(1) : c + IW'(1);
    k_first_ok  = upper_mode ? (k_first > r) : (k_first < r);
    k_nx        = upper_mode ? k - IW'(1) : k + IW'(1);
    k_nx_ok     = upper_mode ? (k_nx > r) : (k_nx < r);
    row_more    = upper_mode ? (r != IW'(0)) : (r_ext + 1'b1 < (DW+1)'(dim));
    row_nx      = upper_mode ? r - IW'(1) : r + IW'(1);
    col_more    = c_ext + 1'b1 < (DW+1)'(dim);
    pivot_state = unit_diagonal ? ST_WR : ST_PRD;
    out_zero    = upper_mode ? (r > c) : (r < c);
    out_col_end = (r_ext + 1'b1 == (DW+1)'(dim));
    out_last    = out_col_end && (c_ext + 1'b1 == (DW+1)'(dim));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      sing  <= 1'b0;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      if (alu_rsp.zero_div) begin
        sing <= 1'b1;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (TW'(cnt) + TW'(1) >= total) begin
              cnt   <= '0;
              sing  <= 1'b0;
              r     <= '0;
              c     <= '0;
              state <= ST_DIAG;
            end else begin
              cnt <= cnt + AW'(1);
            end
          end
        end
        ST_DIAG: state <= ST_DGO;
        ST_DGO: begin
          if (unit_diagonal) begin
            acc   <= ONE;
            diag  <= ONE;
            state <= ST_WR;
          end else begin
            state <= ST_DGW;
          end
        end
        ST_DGW: begin
          if (alu_rsp.done) begin
            acc   <= alu_res;
            diag  <= alu_res;
            state <= ST_WR;
          end
        end
        ST_OFF: state <= ST_OGO;
        ST_OGO: begin
          if (unit_diagonal) begin
            acc   <= tmi_pkg::sat_neg(src_q);
            k     <= k_first;
            state <= k_first_ok ? ST_KRD : pivot_state;
          end else begin
            state <= ST_OMW;
          end
        end
        ST_OMW: begin
          if (alu_rsp.done) begin
            acc   <= tmi_pkg::sat_neg(alu_res);
            k     <= k_first;
            state <= k_first_ok ? ST_KRD : pivot_state;
          end
        end
        ST_KRD: state <= ST_KGO;
        ST_KGO: state <= ST_KMW;
        ST_KMW: begin
          if (alu_rsp.done) begin
            acc   <= tmi_pkg::sat_sub(acc, alu_res);
            k     <= k_nx;
            state <= k_nx_ok ? ST_KRD : pivot_state;
          end
        end
        ST_PRD: state <= ST_PGO;
        ST_PGO: state <= ST_PDW;
        ST_PDW: begin
          if (alu_rsp.done) begin
            acc   <= alu_res;
            state <= ST_WR;
          end
        end
        ST_WR: begin
          if (row_more) begin
            r     <= row_nx;
            state <= ST_OFF;
          end else if (col_more) begin
            c     <= c + IW'(1);
            r     <= c + IW'(1);
            state <= ST_DIAG;
          end else begin
            r     <= '0;
            c     <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (out_last) begin
              state <= ST_LOAD;
            end else if (out_col_end) begin
              r <= '0;
              c <= c + IW'(1);
            end else begin
              r <= r + IW'(1);
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // The emit state re-reads the inverse store every cycle at (r,c); the word
  // is valid from the cycle after the address settles.
  logic emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_ready <= 1'b0;
    end else begin
      emit_ready <= (state == ST_EMIT) && !out_acc;
    end
  end

  assign out_valid       = (state == ST_EMIT) && emit_ready;
  assign inverse_element = out_zero ? 32'sd0 : inv_q;
  assign last_element    = out_last;
  assign singular        = sing;

endmodule

`default_nettype wire

// ----- hdl/tmi_checker.sv -----
// ----------------------------------------------------------------------------
// tmi_checker
// Port-level checks for the triangular inverse, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmi_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] inverse_element,
  input wire logic               last_element,
  input wire logic               singular
);

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result word is offered");

  // A loaded word is never followed at once by a result word.
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result word offered right after a loaded word");

  // Until the last word leaves, no new matrix is taken.
  a_mid_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_element |=> !in_ready)
    else $error("input reopened before the last result word");

  // After the last word the block goes back to loading.
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_element |=> in_ready && !out_valid)
    else $error("block did not return to loading after the last word");

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inverse_element)
      && $stable(singular) && $stable(last_element))
    else $error("stalled result word changed");

endmodule

bind triangular_matrix_inverse tmi_checker u_tmi_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .inverse_element (inverse_element),
  .last_element    (last_element),
  .singular        (singular)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Triangular matrix inverse testbench
// Loads Q16.16 matrices word by word under several register settings,
// predicts every inverse entry in the scoreboard, and compares the
// words leaving the block one field at a time, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DIM_MAX      = 8;
  localparam int          FRAC         = 16;
  localparam int          RANDOM_WORDS = 160;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [1:0]  REG_SPARE    = 2'd3;  // no register lives here
  localparam logic [31:0] FX_ONE       = 32'h0001_0000;

  // One word of the inverse as the block should deliver it.
  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               sing;
  } inv_word_t;

  // The scoreboard keeps its own copy of the registers and the source store,
  // and turns each completed matrix into the queue of expected inverse words.
  class inverse_scoreboard;
    bit                 upper;
    bit                 unit_diag;
    logic [3:0]         size_reg;
    logic signed [31:0] src [DIM_MAX*DIM_MAX];
    logic signed [31:0] inv [DIM_MAX*DIM_MAX];
    int                 load_cnt;
    bit                 sing_flag;
    inv_word_t          inverse_q[$];
    int                 errors;

    function void clear();
      upper = 0;
      unit_diag = 0;
      size_reg = 4'd8;
      load_cnt = 0;
      sing_flag = 0;
      errors = 0;
      inverse_q.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] data);
      case (idx)
        tmi_pkg::REG_UPPER_MODE:  upper = data[0];
        tmi_pkg::REG_UNIT_DIAG:   unit_diag = data[0];
        tmi_pkg::REG_SIZE_IN_USE: size_reg = data;
        default: ;
      endcase
    endfunction

    function int dim();
      if (size_reg == 0) return 1;
      if (size_reg > DIM_MAX) return DIM_MAX;
      return int'(size_reg);
    endfunction

    function logic signed [31:0] from_magnitude(longint unsigned m, bit neg);
      if (neg) return (m >= 64'h8000_0000) ? tmi_pkg::Q_MIN : -$signed(m[31:0]);
      return (m > 64'h7FFF_FFFF) ? tmi_pkg::Q_MAX : $signed(m[31:0]);
    endfunction

    function logic signed [31:0] clip(longint v);
      if (v > longint'(tmi_pkg::Q_MAX)) return tmi_pkg::Q_MAX;
      if (v < longint'(tmi_pkg::Q_MIN)) return tmi_pkg::Q_MIN;
      return v[31:0];
    endfunction

    // Product rounded half away from zero on the magnitude.
    function logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
      longint          p;
      longint unsigned m;
      p = longint'(a) * longint'(b);
      m = p < 0 ? -p : p;
      m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
      return from_magnitude(m, p < 0);
    endfunction

    // Quotient rounded half away from zero; a zero divisor saturates.
    function logic signed [31:0] fx_div(logic signed [31:0] x, logic signed [31:0] y);
      longint unsigned num, den;
      if (y == 0) begin
        sing_flag = 1;
        return x >= 0 ? tmi_pkg::Q_MAX : tmi_pkg::Q_MIN;
      end
      num = (x < 0 ? -longint'(x) : longint'(x)) << FRAC;
      den = y < 0 ? -longint'(y) : longint'(y);
      return from_magnitude((2 * num + den) / (2 * den), (x < 0) != (y < 0));
    endfunction

    function void substitute(int n);
      logic signed [31:0] diag, acc;
      int                 c, r, k;
      sing_flag = 0;
      for (int i = 0; i < n * n; i++) inv[i] = '0;
      for (c = 0; c < n; c++) begin
        diag = unit_diag ? FX_ONE : fx_div(FX_ONE, src[c + c*n]);
        inv[c + c*n] = diag;
        // Walk away from the diagonal toward the selected triangle.
        r = upper ? c - 1 : c + 1;
        while (upper ? r >= 0 : r < n) begin
          acc = unit_diag ? src[r + c*n] : fx_mul(src[r + c*n], diag);
          acc = clip(-longint'(acc));
          k = upper ? c - 1 : c + 1;
          while (upper ? k > r : k < r) begin
            acc = clip(longint'(acc) - longint'(fx_mul(inv[k + c*n], src[r + k*n])));
            k = upper ? k - 1 : k + 1;
          end
          if (!unit_diag) acc = fx_div(acc, src[r + r*n]);
          inv[r + c*n] = acc;
          r = upper ? r - 1 : r + 1;
        end
      end
    endfunction

    function void note_input(logic signed [31:0] e);
      int        n;
      inv_word_t w;
      n = dim();
      if (load_cnt < DIM_MAX*DIM_MAX) src[load_cnt] = e;
      load_cnt++;
      if (load_cnt < n * n) return;
      load_cnt = 0;
      substitute(n);
      for (int i = 0; i < n * n; i++) begin
        w.value = inv[i];
        w.last = (i == n * n - 1);
        w.sing = sing_flag;
        inverse_q.push_back(w);
      end
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [31:0] value, logic last, logic sing);
      inv_word_t w;
      if (inverse_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", value));
        return;
      end
      w = inverse_q.pop_front();
      if (value !== w.value)
        report_mismatch($sformatf("inverse_element %h, want %h", value, w.value));
      if (last !== w.last)
        report_mismatch($sformatf("last_element %b, want %b", last, w.last));
      if (sing !== w.sing)
        report_mismatch($sformatf("singular %b, want %b", sing, w.sing));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [1:0]         wr_index = '0;
  logic [3:0]         wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] element = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] inverse_element;
  logic               last_element;
  logic               singular;

  inverse_scoreboard sb = new();
  int                cycles = 0;
  int                burst_left = 0;
  int                words_sent = 0;

  triangular_matrix_inverse u_dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .element(element),
    .out_valid(out_valid), .out_ready(out_ready),
    .inverse_element(inverse_element), .last_element(last_element),
    .singular(singular)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut short if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Every word that leaves the block is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(inverse_element, last_element, singular);
  end

  // The receiver changes its mood now and then: always ready, ready at random,
  // or held off in long stretches.
  always begin
    int mode, span;
    mode = $urandom_range(0, 2);
    span = $urandom_range(5, 60);
    repeat (span) begin
      @(negedge clk);
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        default: out_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Waits until the last expected word has come and the block has settled.
  // The sender is idle meanwhile, so no stale word slips in.
  task wait_idle();
    in_valid = 1'b0;
    while (sb.inverse_q.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [3:0] data);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task set_mode(bit up, bit unit, logic [3:0] size);
    wait_idle();
    write_reg(tmi_pkg::REG_UPPER_MODE, {3'b0, up});
    write_reg(tmi_pkg::REG_UNIT_DIAG, {3'b0, unit});
    write_reg(tmi_pkg::REG_SIZE_IN_USE, size);
  endtask

  // Sends one word. The sender runs in bursts; between bursts valid drops.
  // Valid stays high across words within a burst.
  task send_word(logic signed [31:0] e);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid = 1'b1;
    element = e;
    do @(posedge clk); while (!in_ready);
    sb.note_input(e);
    words_sent++;
    @(negedge clk);
  endtask

  function logic signed [31:0] pick_value(bit on_diag);
    case ($urandom_range(0, 7))
      0: return on_diag && $urandom_range(0, 9) != 0 ? FX_ONE : 32'sd0;
      1: return FX_ONE;
      2: return -FX_ONE;
      3, 4: return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
      5: return $urandom;
      6: return $urandom_range(0, 1) ? tmi_pkg::Q_MAX : tmi_pkg::Q_MIN;
      default: return $signed($urandom_range(1, 255)) - 32'sd128;
    endcase
  endfunction

  task send_matrix(int n);
    for (int i = 0; i < n * n; i++)
      send_word(pick_value((i % n) == (i / n)));
  endtask

  initial begin
    int         r;
    logic [3:0] size;
    sb.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A write to the spare index must change nothing.
    write_reg(REG_SPARE, 4'hF);

    // Directed part: a singular 1x1, the most negative diagonal, then the
    // extremes in both triangles, with and without a unit diagonal.
    set_mode(0, 0, 4'd1);
    send_word(32'sd0);
    send_word(tmi_pkg::Q_MIN);
    send_word(tmi_pkg::Q_MAX);
    set_mode(0, 0, 4'd2);
    send_word(FX_ONE);  send_word(tmi_pkg::Q_MAX);
    send_word(tmi_pkg::Q_MIN); send_word(-FX_ONE);
    set_mode(1, 1, 4'd2);
    send_word(32'sd0);  send_word(tmi_pkg::Q_MIN);
    send_word(tmi_pkg::Q_MAX); send_word(32'sd0);
    set_mode(1, 0, 4'd3);
    send_word(32'sh2_0000); send_word(tmi_pkg::Q_MIN); send_word(tmi_pkg::Q_MIN);
    send_word(tmi_pkg::Q_MAX); send_word(32'sd0); send_word(tmi_pkg::Q_MIN);
    send_word(tmi_pkg::Q_MAX); send_word(32'sd7); send_word(32'sh3_0000);
    // A size of zero acts as one.
    set_mode(0, 1, 4'd0);
    send_word(32'sd12345);

    // Random part, mostly small sizes; every mode change waits for the
    // previous inverse to drain completely.
    while (words_sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 19);
      if (r < 14)      size = 4'($urandom_range(1, 4));
      else if (r < 16) size = 4'($urandom_range(5, 7));
      else if (r == 16) size = 4'd8;
      else if (r == 17) size = 4'd0;
      else             size = 4'($urandom_range(9, 15));
      set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), size);
      repeat ($urandom_range(1, 3)) send_matrix(sb.dim());
    end
    in_valid = 1'b0;

    while (sb.inverse_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
